// ===== design/cpd_pkg.sv =====
// Package with types and constants for closest_pair_distance.
package cpd_pkg;

  localparam int unsigned MaxPointsDef = 1024;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned SqBits       = 33;
  localparam int unsigned FixBits      = 25;

  typedef struct packed {
    logic signed [CoordBitsDef-1:0] point_x;
    logic signed [CoordBitsDef-1:0] point_y;
    logic                           last_point;
  } in_item_t;

  typedef struct packed {
    logic [SqBits-1:0]  min_dist_sq;
    logic [FixBits-1:0] min_dist_fixed;
    logic               no_pair;
    logic               overflow;
  } out_item_t;

endpackage

// ===== design/cpd_cell.sv =====
// One cell of the comparison chain: holds a point, measures the passing point against it.
module cpd_cell #(
  parameter int unsigned CoordBits = cpd_pkg::CoordBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                flush_i,
  input  logic                                in_vld_i,
  input  logic                                in_open_i,
  input  logic signed [CoordBits-1:0]         in_x_i,
  input  logic signed [CoordBits-1:0]         in_y_i,
  input  logic [cpd_pkg::SqBits-1:0]          in_best_i,
  output logic                                out_vld_o,
  output logic                                out_open_o,
  output logic signed [CoordBits-1:0]         out_x_o,
  output logic signed [CoordBits-1:0]         out_y_o,
  output logic [cpd_pkg::SqBits-1:0]          out_best_o
);
  import cpd_pkg::*;

  localparam int unsigned DBits = CoordBits + 1;
  localparam int unsigned PBits = 2 * DBits;
  localparam logic [PBits:0] SqMaxW = PBits + 1 > SqBits ?
      (PBits+1)'({SqBits{1'b1}}) : {(PBits+1){1'b1}};

  logic                       held_q;
  logic signed [CoordBits-1:0] px_q, py_q;
  logic                       vld_q, vld2_q;
  logic                       open_q, open2_q;
  logic signed [CoordBits-1:0] x_q, y_q, x2_q, y2_q;
  logic [SqBits-1:0]          best_q, best2_q;
  logic [DBits-1:0]           dx_q, dy_q;
  logic                       cmp_q;
  logic                       load;
  logic signed [DBits-1:0]    sdx, sdy;
  logic [PBits:0]             sum;
  logic [SqBits-1:0]          sat;

  // A passing item that has no home yet settles in the first free cell.
  assign load = in_vld_i && in_open_i && !held_q;

  // Stage one: absolute coordinate differences against the held point.
  assign sdx = DBits'(in_x_i) - DBits'(px_q);
  assign sdy = DBits'(in_y_i) - DBits'(py_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      vld_q  <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld_q  <= in_vld_i;
      vld2_q <= vld_q;
      if (flush_i) begin
        held_q <= 1'b0;
      end else if (load) begin
        held_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q <= in_x_i;
      py_q <= in_y_i;
    end
    x_q    <= in_x_i;
    y_q    <= in_y_i;
    best_q <= in_best_i;
    open_q <= in_open_i && !load;
    cmp_q  <= held_q;
    dx_q   <= sdx[DBits-1] ? DBits'(-sdx) : DBits'(sdx);
    dy_q   <= sdy[DBits-1] ? DBits'(-sdy) : DBits'(sdy);
  end

  // Stage two: square, add, saturate and keep the smaller distance.
  assign sum = (PBits+1)'(dx_q * dx_q) + (PBits+1)'(dy_q * dy_q);
  assign sat = (sum > SqMaxW) ? {SqBits{1'b1}} : SqBits'(sum);

  always_ff @(posedge clk_i) begin
    x2_q    <= x_q;
    y2_q    <= y_q;
    open2_q <= open_q;
    best2_q <= (cmp_q && sat < best_q) ? sat : best_q;
  end

  assign out_vld_o  = vld2_q;
  assign out_open_o = open2_q;
  assign out_x_o    = x2_q;
  assign out_y_o    = y2_q;
  assign out_best_o = best2_q;
endmodule

// ===== design/cpd_sqrt.sv =====
// Bit-serial integer square root giving the distance with eight fraction bits.
module cpd_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cpd_pkg::SqBits-1:0]    sq_i,
  output logic                          done_o,
  output logic [cpd_pkg::FixBits-1:0]   root_o
);
  import cpd_pkg::*;

  localparam int unsigned VBits = SqBits + 16 + 1;
  localparam int unsigned RBits = VBits / 2;
  localparam int unsigned CntBits = $clog2(RBits + 1);

  logic [VBits-1:0]   rem_q;
  logic [RBits-1:0]   root_q;
  logic [VBits-1:0]   val_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [VBits+1:0]   trial;
  logic [VBits+1:0]   rem_sh;

  // Restoring method: two radicand bits enter per step.
  assign rem_sh = {rem_q, val_q[VBits-1 -: 2]};
  assign trial  = rem_sh - (VBits+2)'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(RBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= {1'b0, sq_i, 16'h0000};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[VBits-3:0], 2'b00};
      if (!trial[VBits+1]) begin
        rem_q  <= VBits'(trial);
        root_q <= {root_q[RBits-2:0], 1'b1};
      end else begin
        rem_q  <= VBits'(rem_sh);
        root_q <= {root_q[RBits-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = (root_q > RBits'({FixBits{1'b1}})) ? {FixBits{1'b1}} : FixBits'(root_q);
endmodule

// ===== design/closest_pair_distance.sv =====
// Top level of closest_pair_distance: point chain, sequencer and square root.
//
//   channel | valid   | stall   | payload
//   in      | valid_i | stall_o | in_item_i  (cpd_pkg::in_item_t)
//   out     | valid_o | stall_i | out_item_o (cpd_pkg::out_item_t)
//
// Each point is taken in one cycle while the input is not stalled: it walks
// the cell chain, where every occupied cell compares it with its held point,
// and the first free cell keeps it. Points past capacity are not sent into the
// chain. Each stored point passes the stage-one and stage-two registers of
// every cell; as it leaves the chain the running minimum is registered, and
// once every stored point has left, the square root runs before the result
// shows. Reset empties the chain. Input is stalled during a search and while a result waits to be taken.
module closest_pair_distance #(
  parameter int unsigned MaxPoints = cpd_pkg::MaxPointsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  cpd_pkg::in_item_t   in_item_i,
  output logic                valid_o,
  input  logic                stall_i,
  output cpd_pkg::out_item_t  out_item_o
);
  import cpd_pkg::*;

  localparam int unsigned CntBits = $clog2(MaxPoints + 1);

  typedef enum logic [3:0] {
    StLoad  = 4'b0001,
    StDrain = 4'b0010,
    StRoot  = 4'b0100,
    StOut   = 4'b1000
  } state_e;

  state_e               state_q;
  logic [CntBits-1:0]   count_q;
  logic [CntBits-1:0]   exit_cnt_q;
  logic                 drop_q;
  logic                 acc;
  logic                 store;
  logic                 flush;
  logic                 start_root, root_done;
  logic [FixBits-1:0]   root;
  logic [SqBits-1:0]    best_q;
  logic [FixBits-1:0]   fix_q;
  logic                 no_pair_q, ovf_q;

  logic                            c_vld  [MaxPoints+1];
  logic                            c_open [MaxPoints+1];
  logic signed [CoordBitsDef-1:0]  c_x    [MaxPoints+1];
  logic signed [CoordBitsDef-1:0]  c_y    [MaxPoints+1];
  logic [SqBits-1:0]               c_best [MaxPoints+1];

  assign stall_o = (state_q != StLoad);
  assign acc     = valid_i && !stall_o;
  assign store   = acc && (count_q != CntBits'(MaxPoints));
  assign flush   = (state_q == StOut) && !stall_i;

  assign c_vld[0]  = store;
  assign c_open[0] = 1'b1;
  assign c_x[0]    = in_item_i.point_x;
  assign c_y[0]    = in_item_i.point_y;
  assign c_best[0] = {SqBits{1'b1}};

  // The chain: cell k ends up holding the point whose arrival index is k.
  for (genvar k = 0; k < MaxPoints; k++) begin : g_cell
    cpd_cell #(.CoordBits(CoordBitsDef)) u_cell (
      .clk_i,
      .rst_ni,
      .flush_i    (flush),
      .in_vld_i   (c_vld[k]),
      .in_open_i  (c_open[k]),
      .in_x_i     (c_x[k]),
      .in_y_i     (c_y[k]),
      .in_best_i  (c_best[k]),
      .out_vld_o  (c_vld[k+1]),
      .out_open_o (c_open[k+1]),
      .out_x_o    (c_x[k+1]),
      .out_y_o    (c_y[k+1]),
      .out_best_o (c_best[k+1])
    );
  end

  // The search is over once every stored point of the set has left the chain.
  assign start_root = (state_q == StDrain) && (exit_cnt_q == count_q);

  cpd_sqrt u_sqrt (
    .clk_i,
    .rst_ni,
    .start_i (start_root),
    .sq_i    (best_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  // Sequencer and running minimum over points leaving the chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      count_q    <= '0;
      exit_cnt_q <= '0;
      drop_q     <= 1'b0;
      best_q     <= {SqBits{1'b1}};
    end else begin
      if (flush) begin
        count_q    <= '0;
        exit_cnt_q <= '0;
        drop_q     <= 1'b0;
        best_q     <= {SqBits{1'b1}};
      end else begin
        if (store) begin
          count_q <= count_q + 1'b1;
        end else if (acc) begin
          drop_q <= 1'b1;
        end
        if (c_vld[MaxPoints]) begin
          exit_cnt_q <= exit_cnt_q + 1'b1;
          if (c_best[MaxPoints] < best_q) begin
            best_q <= c_best[MaxPoints];
          end
        end
      end
      case (state_q)
        StLoad: begin
          if (acc && in_item_i.last_point) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (start_root) begin
            state_q <= StRoot;
          end
        end
        StRoot: begin
          if (root_done) begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!stall_i) begin
            state_q <= StLoad;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (state_q == StRoot && root_done) begin
      no_pair_q <= (count_q < CntBits'(2));
      ovf_q     <= drop_q;
      fix_q     <= root;
    end
  end

  assign valid_o                   = (state_q == StOut);
  assign out_item_o.min_dist_sq    = no_pair_q ? '0 : best_q;
  assign out_item_o.min_dist_fixed = no_pair_q ? '0 : fix_q;
  assign out_item_o.no_pair        = no_pair_q;
  assign out_item_o.overflow       = ovf_q;
endmodule

// ===== test/tb_top.sv =====
// Testbench for closest_pair_distance: random point sets checked against a pair-scan predictor.
`timescale 1ns / 1ps

module tb_top;
  import cpd_pkg::*;

  localparam int unsigned NumPoints = MaxPointsDef;
  localparam longint unsigned SqMax = (64'd1 << SqBits) - 1;
  localparam longint unsigned FixMax = (64'd1 << FixBits) - 1;
  localparam int unsigned CycleLimit = 20000000;

  logic clk_i;
  logic rst_ni;
  logic valid_i;
  logic stall_o;
  in_item_t in_item_i;
  logic valid_o;
  logic stall_i;
  out_item_t out_item_o;

  closest_pair_distance i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .in_item_i(in_item_i), .valid_o(valid_o), .stall_i(stall_i),
    .out_item_o(out_item_o)
  );

  // Clock with a period of 2 ns.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Predictor state: the points of the open set.
  longint set_x[NumPoints];
  longint set_y[NumPoints];
  int unsigned set_count;
  bit set_dropped;

  in_item_t point_queue[$];
  out_item_t expected_distances[$];
  int unsigned error_count;
  int unsigned cycle_count = 0;
  int unsigned out_hold;
  bit source_pause;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Stores one accepted point and, on the closing point, predicts the result.
  task automatic predict_point(input in_item_t p);
    out_item_t r;
    longint unsigned best;
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned d;
    longint unsigned fix;
    if (set_count < NumPoints) begin
      set_x[set_count] = longint'(p.point_x);
      set_y[set_count] = longint'(p.point_y);
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!p.last_point) return;
    r = '0;
    if (set_count < 2) begin
      r.no_pair = 1'b1;
    end else begin
      best = SqMax;
      for (int i = 0; i + 1 < set_count; i++) begin
        for (int j = i + 1; j < set_count; j++) begin
          dx = (set_x[i] >= set_x[j]) ? set_x[i] - set_x[j] : set_x[j] - set_x[i];
          dy = (set_y[i] >= set_y[j]) ? set_y[i] - set_y[j] : set_y[j] - set_y[i];
          d = dx * dx + dy * dy;
          if (d > SqMax) d = SqMax;
          if (d < best) best = d;
        end
      end
      fix = isqrt(best << 16);
      if (fix > FixMax) fix = FixMax;
      r.min_dist_sq = best[SqBits-1:0];
      r.min_dist_fixed = fix[FixBits-1:0];
    end
    r.overflow = set_dropped;
    expected_distances.push_back(r);
    set_count = 0;
    set_dropped = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic int unsigned gap_length();
    if ($urandom_range(9) < 7) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic in_item_t make_point(input bit closing, input int unsigned mode);
    in_item_t p;
    p.point_x = 16'($urandom());
    p.point_y = 16'($urandom());
    // Small coordinates give near and coincident points.
    if (mode == 1) begin
      p.point_x = $signed(16'($urandom_range(8))) - 16'sd4;
      p.point_y = $signed(16'($urandom_range(8))) - 16'sd4;
    end else if (mode == 2) begin
      p.point_x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      p.point_y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end
    p.last_point = closing;
    return p;
  endfunction

  // Driver: offers queued points with random gaps.
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
      in_item_i <= '0;
      in_gap <= 0;
    end else begin
      if (valid_i && !stall_o) predict_point(in_item_i);
      if (valid_i && stall_o) begin
        // Hold the stalled item.
      end else if (in_gap != 0) begin
        valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (point_queue.size() != 0 && !source_pause) begin
        valid_i <= 1'b1;
        in_item_i <= point_queue.pop_front();
        in_gap <= gap_length();
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // Monitor: random stall on the result side and comparison with predictions.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      stall_i <= 1'b0;
      out_hold <= 0;
    end else begin
      if (valid_o && !stall_i) begin
        if (expected_distances.size() == 0) begin
          $display("unexpected result at cycle %0d", cycle_count);
          error_count++;
        end else begin
          want = expected_distances.pop_front();
          if (out_item_o.min_dist_sq !== want.min_dist_sq)
            report_mismatch("min_dist_sq", out_item_o.min_dist_sq, want.min_dist_sq);
          if (out_item_o.min_dist_fixed !== want.min_dist_fixed)
            report_mismatch("min_dist_fixed", out_item_o.min_dist_fixed, want.min_dist_fixed);
          if (out_item_o.no_pair !== want.no_pair)
            report_mismatch("no_pair", out_item_o.no_pair, want.no_pair);
          if (out_item_o.overflow !== want.overflow)
            report_mismatch("overflow", out_item_o.overflow, want.overflow);
        end
      end
      if (out_hold != 0) begin
        stall_i <= 1'b1;
        out_hold <= out_hold - 1;
      end else begin
        stall_i <= ($urandom_range(9) < 2);
        if ($urandom_range(199) == 0) out_hold <= $urandom_range(3000, 2500);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_set(input int unsigned n, input int unsigned mode);
    for (int i = 0; i < n; i++) point_queue.push_back(make_point(i == n - 1, mode));
  endtask

  task automatic wait_drained();
    while (point_queue.size() != 0 || valid_i || expected_distances.size() != 0)
      @(posedge clk_i);
  endtask

  // Stimulus: directed sets, then random sets of mostly small size.
  initial begin
    int unsigned total;
    int unsigned n;
    error_count = 0;
    set_count = 0;
    set_dropped = 1'b0;
    source_pause = 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Single point, coincident pair, extreme corners, near points.
    add_set(1, 0);
    add_set(2, 1);
    point_queue.push_back('{16'sh8000, 16'sh8000, 1'b0});
    point_queue.push_back('{16'sh7fff, 16'sh7fff, 1'b1});
    point_queue.push_back('{16'sh7fff, 16'sh8000, 1'b0});
    point_queue.push_back('{16'sh8000, 16'sh7fff, 1'b1});
    point_queue.push_back('{16'sh0005, 16'shfffd, 1'b0});
    point_queue.push_back('{16'sh0005, 16'shfffd, 1'b1});
    add_set(4, 2);
    add_set(6, 0);
    add_set(5, 1);
    // The sender waits until every result is back.
    repeat (20) @(posedge clk_i);
    source_pause = 1'b1;
    while (valid_i || expected_distances.size() != 0) @(posedge clk_i);
    source_pause = 1'b0;
    wait_drained();
    // Full store followed by dropped points, the closing one too.
    add_set(NumPoints + 3, 0);
    wait_drained();
    total = 0;
    while (total < 60) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
      add_set(n, $urandom_range(2));
      total += n;
    end
    wait_drained();
    repeat (2 * NumPoints + 100) @(posedge clk_i);
    if (error_count == 0 && expected_distances.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
